/* rtl/core/brb_pkg.sv */
package brb_pkg;

  localparam int WORD_BITS   = 32;
  localparam int SET_WORDS   = 8;
  localparam int SET_MEMBERS = WORD_BITS * SET_WORDS;
  localparam int MEMBER_W    = $clog2(SET_MEMBERS);
  localparam int IDX_W       = (SET_WORDS > 1) ? $clog2(SET_WORDS) : 1;

  typedef logic [1:0] action_t;

  localparam action_t ACT_ELEMENT = 2'd0;
  localparam action_t ACT_RANGE   = 2'd1;
  localparam action_t ACT_FINISH  = 2'd2;

  typedef struct packed {
    logic                   load;
    logic [SET_MEMBERS-1:0] bits;
    logic                   err;
  } snap_req_t;

endpackage

/* rtl/core/brb_if.sv */
interface brb_in_if;
  import brb_pkg::*;

  logic          valid;
  logic          ready;
  action_t       action;
  logic [7:0]    element_value;

  modport source(output valid, action, element_value, input ready);
  modport sink(input valid, action, element_value, output ready);
endinterface

interface brb_out_if;
  import brb_pkg::*;

  logic          valid;
  logic          ready;
  logic [31:0]   set_word;
  logic [2:0]    word_index;
  logic          last_word;
  logic          range_error;

  modport source(output valid, set_word, word_index, last_word, range_error, input ready);
  modport sink(input valid, set_word, word_index, last_word, range_error, output ready);
endinterface

/* rtl/core/brb_accum.sv */
module brb_accum (
  input  logic               clk,
  input  logic               rst,
  brb_in_if.sink             tokens,
  input  logic               emit_free,
  output brb_pkg::snap_req_t snap_req
);
  import brb_pkg::*;

  logic                   tok_v;
  action_t                tok_action;
  logic [MEMBER_W-1:0]    tok_value;
  logic [SET_MEMBERS-1:0] member_bits;
  logic                   range_pending;
  logic [MEMBER_W-1:0]    low_bound;
  logic                   error_seen;

  logic                   accept;
  logic                   fire;
  logic [MEMBER_W-1:0]    lo;
  logic [MEMBER_W-1:0]    hi;
  logic                   reversed;
  logic [SET_MEMBERS-1:0] span_mask;

  assign fire          = tok_v && ((tok_action != ACT_FINISH) || emit_free);
  assign tokens.ready  = !tok_v || fire;
  assign accept        = tokens.valid && tokens.ready;

  assign lo       = range_pending ? low_bound : tok_value;
  assign hi       = tok_value;
  assign reversed = range_pending && (tok_value < low_bound);

  always_comb begin
    for (int i = 0; i < SET_MEMBERS; i++) begin
      span_mask[i] = (MEMBER_W'(i) >= lo) && (MEMBER_W'(i) <= hi);
    end
  end

  assign snap_req.load = fire && (tok_action == ACT_FINISH);
  assign snap_req.bits = member_bits;
  assign snap_req.err  = error_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_v <= 1'b0;
    end else if (accept) begin
      tok_v <= 1'b1;
    end else if (fire) begin
      tok_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tok_action <= tokens.action;
      tok_value  <= tokens.element_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      member_bits   <= '0;
      range_pending <= 1'b0;
      low_bound     <= '0;
      error_seen    <= 1'b0;
    end else if (fire) begin
      unique case (tok_action)
        ACT_ELEMENT: begin
          member_bits   <= member_bits | span_mask;
          range_pending <= 1'b0;
          if (!range_pending) begin
            low_bound <= tok_value;
          end
          if (reversed) begin
            error_seen <= 1'b1;
          end
        end
        ACT_RANGE: begin
          range_pending <= 1'b1;
        end
        ACT_FINISH: begin
          member_bits   <= '0;
          range_pending <= 1'b0;
          low_bound     <= '0;
          error_seen    <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  a_stall_holds_token: assert property (@(posedge clk) disable iff (rst)
    !tokens.ready |-> tok_v)
    else $error("input stalled with no token held");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    snap_req.load |=> (member_bits == '0) && !error_seen && !range_pending)
    else $error("set not cleared after finish");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    snap_req.load |-> emit_free)
    else $error("snapshot loaded while emitter busy");

endmodule

/* rtl/core/brb_emit.sv */
module brb_emit (
  input  logic               clk,
  input  logic               rst,
  input  brb_pkg::snap_req_t snap_req,
  output logic               emit_free,
  brb_out_if.source          words
);
  import brb_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SET_WORDS - 1);

  logic [SET_MEMBERS-1:0] snap;
  logic                   err;
  logic                   busy;
  logic [IDX_W-1:0]       idx;

  logic                   fire;
  logic                   last;

  assign fire      = busy && words.ready;
  assign last      = (idx == LAST_IDX);
  assign emit_free = !busy || (fire && last);

  assign words.valid       = busy;
  assign words.set_word    = 32'(snap[WORD_BITS-1:0]);
  assign words.word_index  = 3'(idx);
  assign words.last_word   = last;
  assign words.range_error = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (snap_req.load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fire) begin
      busy <= !last;
      idx  <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_req.load) begin
      snap <= snap_req.bits;
      err  <= snap_req.err;
    end else if (fire) begin
      snap <= snap >> WORD_BITS;
    end
  end

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (fire && last && !snap_req.load) |=> !busy)
    else $error("emitter still busy after last word");

  a_index_steps: assert property (@(posedge clk) disable iff (rst)
    (fire && !last && !snap_req.load) |=> (idx == $past(idx) + 1'b1) && busy)
    else $error("word index did not advance");

  a_load_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    snap_req.load |=> busy && (idx == '0))
    else $error("emission did not start at word zero");

endmodule

/* rtl/core/bitset_range_builder.sv */
// Builds a 256-member bit set from a token stream and emits it as eight
// 32-bit words. An element token sets one bit and becomes the low bound; a
// range token makes the next element the high bound of a span that is set in
// full; a finish token sends the set out lowest word first, last word marked,
// with the error flag (a reversed range, which sets nothing) on every word,
// and starts a fresh set. Each token passes through an input register and
// updates the set from there, so one token is taken per cycle unless a finish
// waits. A finish moves the set into an output shift register that sends one
// word per cycle while the receiver is ready; other tokens keep flowing, and
// only a second finish waits until all eight words of the prior set are taken.
module bitset_range_builder (
  input  logic      clk,
  input  logic      rst,
  brb_in_if.sink    tokens,
  brb_out_if.source words
);
  import brb_pkg::*;

  snap_req_t snap_req;
  logic      emit_free;

  brb_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .tokens    (tokens),
    .emit_free (emit_free),
    .snap_req  (snap_req)
  );

  brb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .snap_req  (snap_req),
    .emit_free (emit_free),
    .words     (words)
  );

endmodule

/* sim/bitset_range_builder_test.sv */
module bitset_range_builder_test;
  import brb_pkg::*;

  localparam action_t ACT_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 195;
  localparam int SETTLE_CYCLES = 20;
  localparam int DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [WORD_BITS-1:0] bits;
    logic [2:0]           idx;
    logic                 last;
    logic                 err;
  } word_rec_t;

  typedef struct packed {
    action_t              act;
    logic [7:0]           val;
    logic                 typed;
    logic [WORD_BITS-1:0] first;
    logic [WORD_BITS-1:0] mid;
    logic [WORD_BITS-1:0] last;
    logic                 err;
  } stim_row_t;

  localparam int DIR_ROWS = 25;

  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ACT_FINISH,  8'd0,   1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{ACT_ELEMENT, 8'd0,   1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_ELEMENT, 8'd255, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_FINISH,  8'd0,   1'b1, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 1'b0},
    '{ACT_RANGE,   8'd0,   1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_ELEMENT, 8'd255, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_FINISH,  8'd255, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0},
    '{ACT_ELEMENT, 8'd255, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_RANGE,   8'd255, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_ELEMENT, 8'd254, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_FINISH,  8'd0,   1'b1, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1},
    '{ACT_UNUSED,  8'haa,  1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_RANGE,   8'h55,  1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_RANGE,   8'haa,  1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_ELEMENT, 8'd33,  1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_FINISH,  8'h55,  1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_ELEMENT, 8'd100, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_RANGE,   8'd0,   1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_ELEMENT, 8'd120, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_RANGE,   8'd0,   1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_ELEMENT, 8'd130, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_FINISH,  8'd0,   1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_ELEMENT, 8'd7,   1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_RANGE,   8'd0,   1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{ACT_FINISH,  8'd0,   1'b1, 32'h0000_0080, 32'h0000_0000, 32'h0000_0000, 1'b0}
  };

  logic clk;
  logic rst;
  bit   calm;
  int   fails;

  brb_in_if  tok_if ();
  brb_out_if word_if ();

  bitset_range_builder u_top (
    .clk    (clk),
    .rst    (rst),
    .tokens (tok_if),
    .words  (word_if)
  );

  logic [SET_MEMBERS-1:0] model_set;
  logic                   model_pending;
  logic [7:0]             model_low;
  logic                   model_err;
  word_rec_t              built [SET_WORDS];
  word_rec_t              set_words_due [$];
  stim_row_t              cur_row;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #(12 * 300000);
    $display("bitset_range_builder regression: fail");
    $finish;
  end

  task note_mismatch(input string what);
    fails++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task fold_token(input action_t act, input logic [7:0] v);
    int hi;
    if (act == ACT_ELEMENT) begin
      if (model_pending) begin
        model_pending = 1'b0;
        if (v < model_low) begin
          model_err = 1'b1;
        end else begin
          hi = v;
          if (hi >= SET_MEMBERS) begin
            model_err = 1'b1;
            hi = SET_MEMBERS - 1;
          end
          for (int m = model_low; m <= hi; m++) model_set[m] = 1'b1;
        end
      end else begin
        model_low = v;
        if (v >= SET_MEMBERS) model_err = 1'b1;
        else model_set[v] = 1'b1;
      end
    end else if (act == ACT_RANGE) begin
      model_pending = 1'b1;
    end else if (act == ACT_FINISH) begin
      for (int k = 0; k < SET_WORDS; k++) begin
        built[k] = '{model_set[k*WORD_BITS +: WORD_BITS], 3'(k),
                     k == SET_WORDS - 1, model_err};
      end
      model_set = '0;
      model_pending = 1'b0;
      model_low = '0;
      model_err = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    word_rec_t rec;
    word_rec_t got;
    if (!rst) begin
      if (tok_if.valid && tok_if.ready) begin
        fold_token(tok_if.action, tok_if.element_value);
        if (tok_if.action == ACT_FINISH) begin
          for (int k = 0; k < SET_WORDS; k++) begin
            rec = built[k];
            if (cur_row.typed) begin
              rec.bits = (k == 0) ? cur_row.first :
                         (k == SET_WORDS - 1) ? cur_row.last : cur_row.mid;
              rec.err = cur_row.err;
            end
            set_words_due.push_back(rec);
          end
        end
      end
      if (word_if.valid && word_if.ready) begin
        got = '{word_if.set_word, word_if.word_index, word_if.last_word,
                word_if.range_error};
        if (set_words_due.size() == 0) begin
          note_mismatch($sformatf("unexpected word %h idx %0d", got.bits, got.idx));
        end else begin
          rec = set_words_due.pop_front();
          if (got !== rec)
            note_mismatch($sformatf("got %h/%0d/%b/%b want %h/%0d/%b/%b",
                                    got.bits, got.idx, got.last, got.err,
                                    rec.bits, rec.idx, rec.last, rec.err));
        end
      end
    end
  end

  always @(negedge clk) begin
    word_if.ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  function automatic logic [7:0] pick_member();
    if ($urandom_range(0, 99) < 30)
      return 8'($urandom_range(0, SET_WORDS - 1) * WORD_BITS +
                ($urandom_range(0, 1) ? WORD_BITS - 1 : 0));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_token(input stim_row_t row);
    while (!calm && $urandom_range(0, 99) < 16) begin
      tok_if.valid <= 1'b0;
      @(negedge clk);
    end
    cur_row = row;
    tok_if.valid <= 1'b1;
    tok_if.action <= row.act;
    tok_if.element_value <= row.val;
    @(posedge clk);
    while (!tok_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    stim_row_t row;
    int rand_items;
    int ntok;
    int pick;
    int drain;
    clk = 1'b0;
    rst = 1'b1;
    calm = 1'b0;
    fails = 0;
    cur_row = '0;
    model_set = '0;
    model_pending = 1'b0;
    model_low = '0;
    model_err = 1'b0;
    tok_if.valid = 1'b0;
    tok_if.action = ACT_ELEMENT;
    tok_if.element_value = '0;
    word_if.ready = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) send_token(dir_rows[i]);

    // hold off until the previous sets have fully drained
    tok_if.valid <= 1'b0;
    while (set_words_due.size() != 0) @(negedge clk);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      ntok = $urandom_range(1, 10);
      repeat (ntok) begin
        calm = (rand_items >= 80 && rand_items < 140);
        pick = $urandom_range(0, 99);
        row = '0;
        row.val = 8'($urandom_range(0, 255));
        if (pick < 40) begin
          row.act = ACT_ELEMENT;
          row.val = pick_member();
          send_token(row);
          rand_items++;
        end else if (pick < 70) begin
          row.act = ACT_RANGE;
          send_token(row);
          row.act = ACT_ELEMENT;
          row.val = ($urandom_range(0, 99) < 85) ?
                    8'($urandom_range(model_low, 255)) : pick_member();
          send_token(row);
          rand_items += 2;
        end else if (pick < 80) begin
          row.act = ACT_RANGE;
          send_token(row);
          rand_items++;
        end else if (pick < 88) begin
          row.act = ACT_UNUSED;
          send_token(row);
          rand_items++;
        end else begin
          row.act = ACT_ELEMENT;
          row.val = ($urandom_range(0, 1)) ? 8'd0 : 8'd255;
          send_token(row);
          rand_items++;
        end
      end
      row = '0;
      row.act = ACT_FINISH;
      row.val = 8'($urandom_range(0, 255));
      send_token(row);
      rand_items++;
    end
    calm = 1'b0;
    tok_if.valid <= 1'b0;

    drain = 0;
    while (set_words_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (set_words_due.size() != 0)
      note_mismatch($sformatf("%0d words never arrived", set_words_due.size()));

    if (fails == 0) begin
      $display("bitset_range_builder regression: pass");
    end else begin
      $display("bitset_range_builder regression: fail");
    end
    $finish;
  end

endmodule
